@@ hw/rtl/afaq_pkg.sv @@
// Shared types and constants for the angle frame average quantizer.
package afaq_pkg;
  localparam int unsigned FRAME_BYTES = 11;
  localparam logic [7:0] HEAD_MARK = 8'hFF;
  localparam logic [7:0] TAIL_MARK = 8'hFE;
  localparam logic [30:0] BAND_RESET [6] = '{31'd6554, 31'd19661, 31'd32768,
                                             31'd45875, 31'd65536, 31'd131072};
  localparam logic [4:0] BAND_LEVEL [6] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd6};
  localparam logic [4:0] LEVEL_TOP = 5'd8;
  localparam logic [7:0] SIGN_BOTH  = 8'd0;
  localparam logic [7:0] SIGN_PITCH = 8'd1;
  localparam logic [7:0] SIGN_YAW   = 8'd2;
  localparam logic [2:0] REG_COUNT = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CONV, ST_SUM, ST_DIV, ST_QUANT, ST_OUT
  } afaq_state_t;

  typedef struct packed {
    logic store_byte;
    logic frame_end;
    logic conv;
    logic sum_step;
    logic div_start;
    logic quant;
  } afaq_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic sum_done;
    logic div_done;
  } afaq_status_t;

  // IEEE single to Q16.16, truncating toward zero, saturating; NaN gives zero.
  function automatic logic signed [31:0] single_to_q(input logic [31:0] bits);
    logic [7:0] expo;
    logic [23:0] mant;
    logic [38:0] mag;
    logic signed [31:0] res;
    expo = bits[30:23];
    mant = {1'b1, bits[22:0]};
    mag = '0;
    res = '0;
    if (expo == 8'hFF) begin
      if (bits[22:0] != 23'd0) res = '0;
      else res = bits[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (expo == 8'd0 || expo < 8'd111) begin
      res = '0;
    end else if (expo >= 8'd142) begin
      res = bits[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      if (expo >= 8'd134) mag = {15'd0, mant} << (expo - 8'd134);
      else mag = {15'd0, mant} >> (8'd134 - expo);
      if (bits[31]) res = (mag >= 39'h80000000) ? 32'sh80000000 : -$signed(mag[31:0]);
      else res = (mag >= 39'h80000000) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
    end
    return res;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    return (v == 32'sh80000000) ? 32'sh7FFFFFFF : -v;
  endfunction
endpackage

@@ hw/rtl/afaq_ctrl.sv @@
// Controller state machine for the angle frame average quantizer.
module afaq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  output logic                  out_valid,
  input  logic                  out_ready,
  output afaq_pkg::afaq_cmd_t   cmd,
  input  afaq_pkg::afaq_status_t status
);
  import afaq_pkg::*;
  afaq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_req_type) cmd.store_byte = 1'b1;
          else begin
            cmd.frame_end = 1'b1;
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (status.frame_ok) begin
          cmd.conv = 1'b1;
          state_nxt = ST_SUM;
        end else state_nxt = ST_OUT;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_done) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: if (status.div_done) state_nxt = ST_QUANT;
      ST_QUANT: begin
        cmd.quant = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

@@ hw/rtl/afaq_datapath.sv @@
// Frame store, sample windows, summing, division and quantizing datapath.
module afaq_datapath #(
  parameter int unsigned RX_BUFFER_BYTES = 64,
  parameter int unsigned WINDOW_DEPTH = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  afaq_pkg::afaq_cmd_t    cmd,
  output afaq_pkg::afaq_status_t status,
  input  logic [7:0]             in_rx_byte,
  input  logic [30:0]            band_limit [6],
  output logic                   out_frame_ok,
  output logic [6:0]             out_frame_length,
  output logic signed [31:0]     out_avg_yaw,
  output logic signed [31:0]     out_avg_pitch,
  output logic signed [4:0]      out_level_yaw,
  output logic signed [4:0]      out_level_pitch
);
  import afaq_pkg::*;
  localparam int CW = $clog2(RX_BUFFER_BYTES + 1);
  localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int NW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 32 + NW;
  localparam int DCW = $clog2(SW + 1);
  localparam logic [CW-1:0] CMAX = CW'(RX_BUFFER_BYTES);

  logic [7:0] store_r [FRAME_BYTES];
  logic [CW-1:0] count_r;
  logic signed [31:0] yaw_w_r [WINDOW_DEPTH];
  logic signed [31:0] pitch_w_r [WINDOW_DEPTH];
  logic [WW-1:0] slot_r;
  logic [NW-1:0] fill_r, n_r;
  logic [WW-1:0] idx_r;
  logic signed [SW-1:0] sy_r, sp_r;
  logic ok_r;
  logic [6:0] len_r;
  // shared restoring divider: both axes iterate together
  logic [SW-1:0] qy_r, qp_r, ry_r, rp_r;
  logic ny_r, np_r, busy_r;
  logic [DCW-1:0] dcnt_r;
  logic signed [31:0] ay_r, ap_r;
  logic signed [4:0] ly_r, lp_r;

  wire hdr_ok = store_r[0] == HEAD_MARK && store_r[FRAME_BYTES-1] == TAIL_MARK;

  function automatic logic signed [4:0] quant(input logic signed [31:0] a,
                                              input logic [30:0] lim [6]);
    logic [31:0] mag;
    logic [4:0] l;
    mag = a[31] ? 32'(-a) : 32'(a);
    l = LEVEL_TOP;
    for (int i = 5; i >= 0; i--) if (mag <= {1'b0, lim[i]}) l = BAND_LEVEL[i];
    return a[31] ? -$signed(l) : $signed(l);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_BYTES; i++) store_r[i] <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        yaw_w_r[i] <= '0;
        pitch_w_r[i] <= '0;
      end
      count_r <= '0;
      slot_r <= '0;
      fill_r <= '0;
      busy_r <= 1'b0;
      ok_r <= 1'b0;
    end else begin
      if (cmd.store_byte && count_r < CMAX) begin
        if (count_r < CW'(FRAME_BYTES)) store_r[count_r[3:0]] <= in_rx_byte;
        count_r <= count_r + 1'b1;
      end
      if (cmd.frame_end) begin
        len_r <= 7'(count_r);
        ok_r <= (count_r != '0) && hdr_ok;
        count_r <= '0;
        ay_r <= '0;
        ap_r <= '0;
        ly_r <= '0;
        lp_r <= '0;
      end
      if (cmd.conv) begin : conv_blk
        logic signed [31:0] y, p;
        y = single_to_q({store_r[4], store_r[3], store_r[2], store_r[1]});
        p = single_to_q({store_r[8], store_r[7], store_r[6], store_r[5]});
        case (store_r[9])
          SIGN_BOTH: begin y = neg_sat(y); p = neg_sat(p); end
          SIGN_PITCH: p = neg_sat(p);
          SIGN_YAW: y = neg_sat(y);
          default: ;
        endcase
        yaw_w_r[slot_r] <= y;
        pitch_w_r[slot_r] <= p;
        slot_r <= (slot_r == WW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        n_r <= (fill_r < NW'(WINDOW_DEPTH)) ? fill_r + 1'b1 : NW'(WINDOW_DEPTH);
        if (fill_r < NW'(WINDOW_DEPTH)) fill_r <= fill_r + 1'b1;
        idx_r <= '0;
        sy_r <= '0;
        sp_r <= '0;
      end
      if (cmd.sum_step) begin
        sy_r <= sy_r + SW'(yaw_w_r[idx_r]);
        sp_r <= sp_r + SW'(pitch_w_r[idx_r]);
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.div_start) begin : ds
        logic signed [SW-1:0] fy, fp;
        fy = sy_r + SW'(yaw_w_r[idx_r]);
        fp = sp_r + SW'(pitch_w_r[idx_r]);
        ny_r <= fy[SW-1];
        np_r <= fp[SW-1];
        qy_r <= fy[SW-1] ? SW'(-fy) : SW'(fy);
        qp_r <= fp[SW-1] ? SW'(-fp) : SW'(fp);
        ry_r <= '0;
        rp_r <= '0;
        dcnt_r <= DCW'(SW);
        busy_r <= 1'b1;
      end
      if (busy_r) begin : dv
        logic [SW:0] ty, tp;
        ty = {ry_r, qy_r[SW-1]};
        tp = {rp_r, qp_r[SW-1]};
        if (ty >= (SW+1)'(n_r)) begin
          ry_r <= SW'(ty - (SW+1)'(n_r)); qy_r <= {qy_r[SW-2:0], 1'b1};
        end else begin
          ry_r <= SW'(ty); qy_r <= {qy_r[SW-2:0], 1'b0};
        end
        if (tp >= (SW+1)'(n_r)) begin
          rp_r <= SW'(tp - (SW+1)'(n_r)); qp_r <= {qp_r[SW-2:0], 1'b1};
        end else begin
          rp_r <= SW'(tp); qp_r <= {qp_r[SW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == DCW'(1)) busy_r <= 1'b0;
      end
      // quotients are settled by now; sign them and take the levels together
      if (cmd.quant) begin : qt
        logic signed [31:0] vy, vp;
        vy = ny_r ? -$signed(qy_r[31:0]) : $signed(qy_r[31:0]);
        vp = np_r ? -$signed(qp_r[31:0]) : $signed(qp_r[31:0]);
        ay_r <= vy;
        ap_r <= vp;
        ly_r <= quant(vy, band_limit);
        lp_r <= quant(vp, band_limit);
      end
    end
  end

  assign status.frame_ok = ok_r;
  assign status.sum_done = (NW'(idx_r) + 1'b1) >= n_r;
  assign status.div_done = !busy_r && !cmd.div_start;
  assign out_frame_ok = ok_r;
  assign out_frame_length = len_r;
  assign out_avg_yaw = ay_r;
  assign out_avg_pitch = ap_r;
  assign out_level_yaw = ly_r;
  assign out_level_pitch = lp_r;
endmodule

@@ hw/rtl/afaq_regs.sv @@
// APB-style register file for the band limits.
module afaq_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [30:0] band_limit [6]
);
  import afaq_pkg::*;
  logic [30:0] lim_r [6];
  wire [2:0] idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) lim_r[i] <= BAND_RESET[i];
    end else if (psel && penable && pwrite && idx < REG_COUNT) begin
      lim_r[idx] <= pwdata[30:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (idx < REG_COUNT) ? {1'b0, lim_r[idx]} : '0;
  assign band_limit = lim_r;
endmodule

@@ hw/rtl/angle_frame_average_quantizer.sv @@
// Top level of the angle frame average quantizer.
//  channel | direction | handshake            | payload
//  in      | input     | in_valid/in_ready    | req_type, rx_byte
//  out     | output    | out_valid/out_ready  | frame_ok .. level_pitch
//  cfg     | input     | APB psel/penable     | six band limits
// A byte item is stored as it is taken. An idle item runs the window summing
// for valid frames, then the bit-serial divider of 35 steps, and goes straight
// to the result for rejected ones, then waits for the result to be taken.
// Reset is synchronous; store and windows clear to zero in the reset cycle.
// A stalled result holds the block; no new item is taken until it leaves.
module angle_frame_average_quantizer #(
  parameter int unsigned RX_BUFFER_BYTES = 64,
  parameter int unsigned WINDOW_DEPTH = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_frame_ok,
  output logic [6:0]         out_frame_length,
  output logic signed [31:0] out_avg_yaw,
  output logic signed [31:0] out_avg_pitch,
  output logic signed [4:0]  out_level_yaw,
  output logic signed [4:0]  out_level_pitch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import afaq_pkg::*;
  afaq_cmd_t cmd;
  afaq_status_t status;
  logic [30:0] band_limit [6];

  afaq_regs u_regs (.clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                    .prdata, .pready, .band_limit);

  afaq_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .in_req_type,
                    .out_valid, .out_ready, .cmd, .status);

  afaq_datapath #(.RX_BUFFER_BYTES(RX_BUFFER_BYTES), .WINDOW_DEPTH(WINDOW_DEPTH))
    u_dp (.clk, .rst_n, .cmd, .status, .in_rx_byte, .band_limit, .out_frame_ok,
          .out_frame_length, .out_avg_yaw, .out_avg_pitch, .out_level_yaw,
          .out_level_pitch);
endmodule

@@ hw/rtl/afaq_checker.sv @@
// Port-level checker for the angle frame average quantizer, with its bind.
module afaq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_req_type,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_frame_ok,
  input logic signed [31:0] out_avg_yaw,
  input logic signed [4:0] out_level_yaw
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_avg_yaw))
    else $error("result dropped");
  a_byte_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type |=> !out_valid)
    else $error("result after byte item");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ok |-> out_avg_yaw == 0 && out_level_yaw == 0)
    else $error("rejected frame with nonzero fields");
endmodule

bind angle_frame_average_quantizer afaq_checker u_chk (.clk, .rst_n, .in_valid,
  .in_ready, .in_req_type, .out_valid, .out_ready, .out_frame_ok, .out_avg_yaw,
  .out_level_yaw);

@@ tb/sv/angle_frame_average_quantizer_test.sv @@
// Testbench for the angle frame average quantizer: random frames checked against a predictor.
module angle_frame_average_quantizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import afaq_pkg::*;

  localparam int unsigned RX_BYTES_MAX = 64;
  localparam int unsigned AVG_DEPTH = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned REG_BAND_ZERO = 0;
  localparam int unsigned REG_BAND_ONE = 1;
  localparam int unsigned REG_BAND_TWO = 2;
  localparam int unsigned REG_BAND_THREE = 3;
  localparam int unsigned REG_BAND_FOUR = 4;
  localparam int unsigned REG_BAND_SIX = 5;
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_IDLE = 1'b1;
  localparam longint Q_TOP = 64'sd2147483647;
  localparam longint Q_BOTTOM = -64'sd2147483648;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic               ok;
    logic [6:0]         len;
    logic signed [31:0] yaw;
    logic signed [31:0] pitch;
    logic signed [4:0]  lvl_yaw;
    logic signed [4:0]  lvl_pitch;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_frame_ok;
  logic [6:0] out_frame_length;
  logic signed [31:0] out_avg_yaw, out_avg_pitch;
  logic signed [4:0] out_level_yaw, out_level_pitch;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  rx_item_t rx_pending[$];
  frame_result_t results_due[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // predictor state
  logic [7:0] store_copy [FRAME_BYTES];
  int unsigned rx_count;
  logic signed [31:0] yaw_hist [AVG_DEPTH];
  logic signed [31:0] pitch_hist [AVG_DEPTH];
  int unsigned hist_slot, hist_fill;
  logic [30:0] band_lim [6];

  // driver and monitor state
  int unsigned burst_left = 0, gap_left = 0;
  int unsigned hold_left = 0, pat_left = 0, pat_mode = 0;
  logic hold_req = 1'b0, hold_used = 1'b0;

  angle_frame_average_quantizer u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_rx_byte,
    .out_valid, .out_ready, .out_frame_ok, .out_frame_length, .out_avg_yaw,
    .out_avg_pitch, .out_level_yaw, .out_level_pitch,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_q(input longint v);
    if (v > Q_TOP) return Q_TOP;
    if (v < Q_BOTTOM) return Q_BOTTOM;
    return v;
  endfunction

  // single precision bit pattern to Q16.16, truncating toward zero
  function automatic longint single_bits_to_q(input logic [31:0] bits);
    int sh;
    longint mag;
    if (bits[30:23] == 8'hFF) begin
      if (bits[22:0] != 0) return 0;
      return bits[31] ? Q_BOTTOM : Q_TOP;
    end
    if (bits[30:23] == 8'd0) return 0;
    sh = int'(bits[30:23]) - 134;
    if (sh >= 8) return bits[31] ? Q_BOTTOM : Q_TOP;
    if (sh <= -24) return 0;
    mag = longint'({1'b1, bits[22:0]});
    mag = (sh >= 0) ? (mag << sh) : (mag >> (-sh));
    return clamp_q(bits[31] ? -mag : mag);
  endfunction

  function automatic logic signed [4:0] step_level(input longint avg);
    longint mag;
    logic [4:0] lvl;
    mag = (avg < 0) ? -avg : avg;
    lvl = LEVEL_TOP;
    for (int i = 5; i >= 0; i--)
      if (mag <= longint'(band_lim[i])) lvl = BAND_LEVEL[i];
    return (avg < 0) ? -$signed(lvl) : $signed(lvl);
  endfunction

  function automatic longint hist_average(input logic signed [31:0] h [AVG_DEPTH],
                                          input int unsigned n);
    longint sum;
    sum = 0;
    for (int unsigned i = 0; i < n; i++) sum += longint'(h[i]);
    return sum / longint'(n);
  endfunction

  task automatic absorb_item(input logic req, input logic [7:0] data);
    frame_result_t r;
    longint yaw, pitch, ay, ap;
    int unsigned n;
    if (req == REQ_BYTE) begin
      if (rx_count < RX_BYTES_MAX) begin
        if (rx_count < FRAME_BYTES) store_copy[rx_count] = data;
        rx_count++;
      end
      return;
    end
    r = '0;
    r.len = rx_count[6:0];
    r.ok = rx_count > 0 && store_copy[0] == HEAD_MARK && store_copy[10] == TAIL_MARK;
    rx_count = 0;
    if (r.ok) begin
      yaw = single_bits_to_q({store_copy[4], store_copy[3], store_copy[2], store_copy[1]});
      pitch = single_bits_to_q({store_copy[8], store_copy[7], store_copy[6], store_copy[5]});
      case (store_copy[9])
        SIGN_BOTH: begin
          yaw = clamp_q(-yaw);
          pitch = clamp_q(-pitch);
        end
        SIGN_PITCH: pitch = clamp_q(-pitch);
        SIGN_YAW: yaw = clamp_q(-yaw);
        default: ;
      endcase
      yaw_hist[hist_slot] = yaw[31:0];
      pitch_hist[hist_slot] = pitch[31:0];
      n = (hist_fill < AVG_DEPTH) ? hist_fill + 1 : AVG_DEPTH;
      ay = hist_average(yaw_hist, n);
      ap = hist_average(pitch_hist, n);
      hist_slot = (hist_slot + 1) % AVG_DEPTH;
      if (hist_fill < AVG_DEPTH) hist_fill++;
      r.yaw = ay[31:0];
      r.pitch = ap[31:0];
      r.lvl_yaw = step_level(ay);
      r.lvl_pitch = step_level(ap);
    end
    results_due.push_back(r);
  endtask

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    logic accepted;
    accepted = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (accepted) begin
        absorb_item(in_req_type, in_rx_byte);
        void'(rx_pending.pop_front());
      end
      if (in_valid && !accepted) begin
        // hold the item until taken
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (rx_pending.size() != 0) begin
        in_valid <= 1'b1;
        in_req_type <= rx_pending[0].req;
        in_rx_byte <= rx_pending[0].data;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = results_due.pop_front();
          if (out_frame_ok !== e.ok)
            report($sformatf("frame_ok %0b, want %0b", out_frame_ok, e.ok));
          if (out_frame_length !== e.len)
            report($sformatf("frame_length %0d, want %0d", out_frame_length, e.len));
          if (out_avg_yaw !== e.yaw)
            report($sformatf("avg_yaw %h, want %h", out_avg_yaw, e.yaw));
          if (out_avg_pitch !== e.pitch)
            report($sformatf("avg_pitch %h, want %h", out_avg_pitch, e.pitch));
          if (out_level_yaw !== e.lvl_yaw)
            report($sformatf("level_yaw %0d, want %0d", out_level_yaw, e.lvl_yaw));
          if (out_level_pitch !== e.lvl_pitch)
            report($sformatf("level_pitch %0d, want %0d", out_level_pitch, e.lvl_pitch));
        end
      end
      if (hold_req && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= 600;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_left <= $urandom_range(16, 96);
          pat_mode <= $urandom_range(0, 2);
        end else begin
          pat_left <= pat_left - 1;
        end
        case (pat_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input int unsigned idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < 6) band_lim[idx] = value[30:0];
  endtask

  task automatic set_bands(input logic [31:0] v [6]);
    for (int unsigned i = 0; i < 6; i++) reg_write(i, v[i]);
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_pending.push_back('{req: REQ_BYTE, data: b});
  endtask

  task automatic push_idle();
    rx_pending.push_back('{req: REQ_IDLE, data: 8'($urandom_range(0, 255))});
  endtask

  task automatic push_frame(input logic [31:0] yaw, input logic [31:0] pitch,
                            input logic [7:0] sign, input logic [7:0] head,
                            input logic [7:0] tail);
    push_byte(head);
    for (int i = 0; i < 4; i++) push_byte(yaw[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_byte(pitch[8*i +: 8]);
    push_byte(sign);
    push_byte(tail);
    push_idle();
  endtask

  function automatic logic [31:0] random_single();
    logic [31:0] b;
    b = $urandom();
    case ($urandom_range(0, 19))
      0: b[30:23] = 8'hFF;
      1: b[30:23] = 8'h00;
      2: b[30:0] = 31'd0;
      3, 4: ;
      5, 6: b[30:23] = 8'($urandom_range(100, 150));
      default: b[30:23] = 8'($urandom_range(118, 132));
    endcase
    return b;
  endfunction

  task automatic random_traffic(input int unsigned n_items);
    int unsigned target, len;
    logic [7:0] sign;
    target = rx_pending.size() + n_items;
    while (rx_pending.size() < target) begin
      if ($urandom_range(0, 9) < 8) begin
        sign = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
        push_frame(random_single(), random_single(), sign, HEAD_MARK, TAIL_MARK);
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 80) : $urandom_range(0, 11);
        for (int unsigned i = 0; i < len; i++)
          push_byte((i == 0 && $urandom_range(0, 1)) ? HEAD_MARK : 8'($urandom()));
        push_idle();
      end
    end
  endtask

  task automatic drain();
    while (rx_pending.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] bands [6];
    for (int i = 0; i < FRAME_BYTES; i++) store_copy[i] = '0;
    for (int i = 0; i < AVG_DEPTH; i++) begin
      yaw_hist[i] = '0;
      pitch_hist[i] = '0;
    end
    rx_count = 0;
    hist_slot = 0;
    hist_fill = 0;
    for (int i = 0; i < 6; i++) band_lim[i] = BAND_RESET[i];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, sign codes, specials, bad marks, short and long frames
    push_idle();
    push_frame(32'h3F800000, 32'hBF000000, 8'd3, HEAD_MARK, TAIL_MARK);
    push_frame(32'hC7000000, 32'h7F800000, SIGN_BOTH, HEAD_MARK, TAIL_MARK);
    push_frame(32'h7FC00000, 32'hFF800000, SIGN_PITCH, HEAD_MARK, TAIL_MARK);
    push_frame(32'h00000001, 32'h477FFFFF, SIGN_YAW, HEAD_MARK, TAIL_MARK);
    push_frame(32'h37000000, 32'h80000000, 8'hFF, HEAD_MARK, TAIL_MARK);
    push_frame(32'h3F800000, 32'h3F800000, 8'd3, 8'h00, TAIL_MARK);
    push_frame(32'h3F800000, 32'h3F800000, 8'd3, HEAD_MARK, 8'hFF);
    push_byte(HEAD_MARK);
    push_byte(8'h00);
    push_idle();
    for (int i = 0; i < 70; i++) push_byte(8'($urandom()));
    push_idle();
    random_traffic(250);
    drain();

    // registers with indexes past the sixth are ignored; top bit of the data is dropped
    reg_write(6, $urandom());
    reg_write(7, $urandom());
    bands = '{32'd3000, 32'd20000, 32'd60000, 32'd150000, 32'd400000, 32'd900000};
    set_bands(bands);
    hold_req <= 1'b1;
    random_traffic(220);
    drain();

    bands = '{default: 32'd0};
    set_bands(bands);
    random_traffic(200);
    drain();

    bands = '{default: 32'hFFFFFFFF};
    set_bands(bands);
    random_traffic(200);
    drain();

    for (int i = 0; i < 6; i++) bands[i] = $urandom_range(0, 300000);
    set_bands(bands);
    random_traffic(200);
    drain();

    if (errors == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/afaq_pkg.sv
hw/rtl/afaq_ctrl.sv
hw/rtl/afaq_datapath.sv
hw/rtl/afaq_regs.sv
hw/rtl/angle_frame_average_quantizer.sv
hw/rtl/afaq_checker.sv
tb/sv/angle_frame_average_quantizer_test.sv
